>>> src/lpp_pkg.sv
// Shared types and constants for the line pack/pad ping-pong core.
// No dependencies; imported by every module of the block.
package lpp_pkg;

    localparam int LINE_CNT_W        = 10;
    localparam int PIXEL_W           = 8;
    localparam int WORD_W            = 2 * PIXEL_W;
    localparam int LINE_WORDS_DEF    = 64;
    localparam int PADDED_WORDS_DEF  = 128;
    localparam logic [LINE_CNT_W-1:0] FRAME_LINES_RESET = LINE_CNT_W'(339);

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               frame_start;
    } in_t;

    typedef struct packed {
        logic [WORD_W-1:0] word_out;
        logic              word_valid;
        logic              frame_start_out;
    } out_t;

    typedef struct packed {
        logic                en;
        logic [1:0]          lane_en;
        logic [PIXEL_W-1:0]  pixel;
    } byte_wr_t;

endpackage

>>> src/lpp_line_ram.sv
// One line store: synchronous RAM with two byte lanes and registered read data.
// Depends on lpp_pkg for the byte write bundle.
module lpp_line_ram #(
    parameter int DEPTH = lpp_pkg::LINE_WORDS_DEF,
    parameter int AW    = 6
) (
    input  logic                      aclk,
    input  lpp_pkg::byte_wr_t         wr,
    input  logic [AW-1:0]             wr_addr,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [lpp_pkg::WORD_W-1:0] rd_data
);
    import lpp_pkg::*;

    logic [1:0][PIXEL_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0]       rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            if (wr.lane_en[1]) begin
                mem[wr_addr][1] <= wr.pixel;
            end
            if (wr.lane_en[0]) begin
                mem[wr_addr][0] <= wr.pixel;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/line_pack_pad_pingpong_core.sv
// Top level: packs pixel pairs into two ping-pong line stores, reads full lines out padded.
// Depends on lpp_pkg and lpp_line_ram.
// A result beat on m_ passes the stage 1 and output registers; writes and reads use one port each.
// Throughput: one beat per cycle without m_ready stalls; at most one byte write, one word read.
// Reset: synchronous active-low aresetn clears all counters, flags and the pipeline;
// frame_lines returns to 339; line store contents stay undefined until written.
module line_pack_pad_pingpong_core #(
    parameter int LINE_WORDS   = lpp_pkg::LINE_WORDS_DEF,
    parameter int PADDED_WORDS = lpp_pkg::PADDED_WORDS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [lpp_pkg::LINE_CNT_W-1:0] cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  lpp_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output lpp_pkg::out_t                 m_data
);
    import lpp_pkg::*;

    localparam int AW   = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
    localparam int WP_W = $clog2(LINE_WORDS + 1);
    localparam int BP_W = $clog2(2 * LINE_WORDS + 1);
    localparam int RI_W = $clog2(PADDED_WORDS + 1);
    localparam logic [WP_W-1:0] WP_FULL  = WP_W'(LINE_WORDS);
    localparam logic [BP_W-1:0] BP_LINE  = BP_W'(2 * LINE_WORDS);
    localparam logic [RI_W-1:0] RI_END   = RI_W'(PADDED_WORDS);
    localparam logic [31:0]     LW32     = 32'(LINE_WORDS);

    logic [LINE_CNT_W-1:0] frame_lines_reg;
    logic [LINE_CNT_W-1:0] lines_in_reg, lines_in_next;
    logic [LINE_CNT_W-1:0] lines_out_reg, lines_out_next;
    logic [BP_W-1:0]       byte_pos_reg, byte_pos_next;
    logic [WP_W-1:0]       word_pos_reg, word_pos_next;
    logic                  half_reg, half_next;
    logic                  fill_sel_reg, fill_sel_next;
    logic                  full_a_reg, full_a_next;
    logic                  full_b_reg, full_b_next;
    logic [RI_W-1:0]       rd_idx_a_reg, rd_idx_a_next;
    logic [RI_W-1:0]       rd_idx_b_reg, rd_idx_b_next;

    logic                  accept;
    logic                  wr_en;
    logic                  wr_sel;
    logic [AW-1:0]         wr_addr;
    logic [RI_W-1:0]       rd_idx;
    logic                  rd_pad;
    logic                  rd_hit;
    logic                  step_valid;
    logic                  step_sof;
    logic                  fwd;
    byte_wr_t              wr_a, wr_b;
    logic                  re_a, re_b;
    logic [AW-1:0]         rd_addr;
    logic [WORD_W-1:0]     rdata_a, rdata_b, rdata;

    logic                  s1_valid_reg;
    logic                  s1_word_valid_reg;
    logic                  s1_sel_b_reg;
    logic                  s1_pad_reg;
    logic                  s1_sof_reg;
    logic                  s1_fwd_hi_reg;
    logic                  s1_fwd_lo_reg;
    logic [PIXEL_W-1:0]    s1_px_reg;
    logic                  s1_adv;
    logic [WORD_W-1:0]     s1_word;

    logic                  m_valid_reg;
    out_t                  m_data_reg;

    assign s1_adv  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign accept  = s_valid && s_ready;

    always_comb begin
        lines_in_next  = lines_in_reg;
        lines_out_next = lines_out_reg;
        byte_pos_next  = byte_pos_reg;
        word_pos_next  = word_pos_reg;
        half_next      = half_reg;
        fill_sel_next  = fill_sel_reg;
        full_a_next    = full_a_reg;
        full_b_next    = full_b_reg;
        rd_idx_a_next  = rd_idx_a_reg;
        rd_idx_b_next  = rd_idx_b_reg;
        wr_en          = 1'b0;

        if (s_data.frame_start) begin
            lines_in_next = '0;
            byte_pos_next = '0;
            word_pos_next = '0;
            fill_sel_next = 1'b0;
        end
        wr_sel  = fill_sel_next;
        wr_addr = AW'(word_pos_next);

        // write side
        if (lines_in_next < frame_lines_reg) begin
            wr_en         = 1'b1;
            byte_pos_next = byte_pos_next + 1'b1;
            if (half_reg) begin
                word_pos_next = word_pos_next + 1'b1;
            end
            half_next = ~half_reg;
            if (word_pos_next == WP_FULL) begin
                if (fill_sel_next) begin
                    full_b_next = 1'b1;
                end else begin
                    full_a_next = 1'b1;
                end
                fill_sel_next = ~fill_sel_next;
                word_pos_next = '0;
            end
            if (byte_pos_next == BP_LINE) begin
                lines_in_next = lines_in_next + 1'b1;
                byte_pos_next = '0;
            end
        end

        // read side, store b wins
        step_valid = full_a_next || full_b_next;
        rd_idx     = full_b_next ? rd_idx_b_reg : rd_idx_a_reg;
        rd_pad     = !(32'(rd_idx) < LW32);
        rd_hit     = step_valid && !rd_pad;
        rd_addr    = AW'(rd_idx);
        step_sof   = step_valid && (lines_out_reg == '0) && (rd_idx == '0);
        fwd        = wr_en && rd_hit && (wr_sel == full_b_next) && (rd_addr == wr_addr);
        if (full_a_next) begin
            rd_idx_a_next = rd_idx_a_reg + 1'b1;
        end
        if (full_b_next) begin
            rd_idx_b_next = rd_idx_b_reg + 1'b1;
        end

        // line control
        if (rd_idx_a_next == RI_END || rd_idx_b_next == RI_END) begin
            lines_out_next = lines_out_next + 1'b1;
        end
        if (lines_out_next == frame_lines_reg) begin
            lines_out_next = '0;
        end
        if (rd_idx_a_next == RI_END) begin
            full_a_next   = 1'b0;
            rd_idx_a_next = '0;
        end
        if (rd_idx_b_next == RI_END) begin
            full_b_next   = 1'b0;
            rd_idx_b_next = '0;
        end
    end

    always_comb begin
        wr_a.en      = accept && wr_en && !wr_sel;
        wr_a.lane_en = half_reg ? 2'b01 : 2'b10;
        wr_a.pixel   = s_data.pixel;
        wr_b         = wr_a;
        wr_b.en      = accept && wr_en && wr_sel;
        re_a         = accept && rd_hit && !full_b_next;
        re_b         = accept && rd_hit && full_b_next;
    end

    lpp_line_ram #(.DEPTH(LINE_WORDS), .AW(AW)) u_store_a (
        .aclk    (aclk),
        .wr      (wr_a),
        .wr_addr (wr_addr),
        .rd_en   (re_a),
        .rd_addr (rd_addr),
        .rd_data (rdata_a)
    );

    lpp_line_ram #(.DEPTH(LINE_WORDS), .AW(AW)) u_store_b (
        .aclk    (aclk),
        .wr      (wr_b),
        .wr_addr (wr_addr),
        .rd_en   (re_b),
        .rd_addr (rd_addr),
        .rd_data (rdata_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_lines_reg <= FRAME_LINES_RESET;
        end else if (cfg_we) begin
            frame_lines_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lines_in_reg  <= '0;
            lines_out_reg <= '0;
            byte_pos_reg  <= '0;
            word_pos_reg  <= '0;
            half_reg      <= 1'b0;
            fill_sel_reg  <= 1'b0;
            full_a_reg    <= 1'b0;
            full_b_reg    <= 1'b0;
            rd_idx_a_reg  <= '0;
            rd_idx_b_reg  <= '0;
        end else if (accept) begin
            lines_in_reg  <= lines_in_next;
            lines_out_reg <= lines_out_next;
            byte_pos_reg  <= byte_pos_next;
            word_pos_reg  <= word_pos_next;
            half_reg      <= half_next;
            fill_sel_reg  <= fill_sel_next;
            full_a_reg    <= full_a_next;
            full_b_reg    <= full_b_next;
            rd_idx_a_reg  <= rd_idx_a_next;
            rd_idx_b_reg  <= rd_idx_b_next;
        end
    end

    // stage 1: RAM read data lands here; same-cycle write is forwarded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_word_valid_reg <= step_valid;
            s1_sel_b_reg      <= full_b_next;
            s1_pad_reg        <= rd_pad;
            s1_sof_reg        <= step_sof;
            s1_fwd_hi_reg     <= fwd && !half_reg;
            s1_fwd_lo_reg     <= fwd && half_reg;
            s1_px_reg         <= s_data.pixel;
        end
    end

    always_comb begin
        rdata   = s1_sel_b_reg ? rdata_b : rdata_a;
        s1_word = {s1_fwd_hi_reg ? s1_px_reg : rdata[WORD_W-1:PIXEL_W],
                   s1_fwd_lo_reg ? s1_px_reg : rdata[PIXEL_W-1:0]};
        if (s1_pad_reg || !s1_word_valid_reg) begin
            s1_word = '0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_data_reg.word_out        <= s1_word;
            m_data_reg.word_valid      <= s1_word_valid_reg;
            m_data_reg.frame_start_out <= s1_sof_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_idle_store_a_index: assert property (@(posedge aclk) disable iff (!aresetn)
        !full_a_reg |-> rd_idx_a_reg == '0)
        else $error("store a read index moved while store a not full");

    a_idle_store_b_index: assert property (@(posedge aclk) disable iff (!aresetn)
        !full_b_reg |-> rd_idx_b_reg == '0)
        else $error("store b read index moved while store b not full");

    a_stall_holds_rdata: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_adv |=> $stable(rdata_a) && $stable(rdata_b))
        else $error("line store read data changed under a stalled beat");

    a_empty_beat_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.word_valid |-> m_data.word_out == '0 && !m_data.frame_start_out)
        else $error("beat without a word carries data or frame start");

endmodule
